// ===== src/llrpd_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// llrpd_pkg: shared types and constants for the lossy log ring
// Field widths, item kind codes and default sizes used by the ring core
// and its storage.
// -----------------------------------------------------------------------------
package llrpd_pkg;

  // default sizes
  localparam int unsigned RingDepthDef   = 4096;
  localparam int unsigned PacketBytesDef = 64;

  // fixed field widths
  localparam int unsigned DataW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned AccW   = 7;
  localparam int unsigned LevelW = 13;

  // item kinds; the fourth code is unused and ignored
  typedef enum logic [KindW-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_OFFER   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

endpackage

// ===== src/llrpd_ring_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// llrpd_ring_ram: byte storage of the log ring
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module llrpd_ring_ram #(
  parameter int unsigned Depth = llrpd_pkg::RingDepthDef
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  logic [llrpd_pkg::DataW-1:0]    wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output logic [llrpd_pkg::DataW-1:0]    rdata_o
);
  import llrpd_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lossy_log_ring_packet_drain_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lossy_log_ring_packet_drain_core: overwrite-oldest log byte ring
// Pushes append at the head (overwriting the oldest byte when full), offers
// stream up to one packet from the tail without removing it, releases drop
// bytes from the tail.
//
//   channel   direction  handshake               payload
//   command   in         start_i, busy_o         kind_i, data_byte_i, accepted_i
//   result    out        result_valid_o (strobe) out_byte_o, last_o, level_o
//
// Push and release finish in the accept cycle; busy_o stays low.
// An offer of n bytes (n = min(level, PACKET_BYTES)) holds busy_o while it
// issues n RAM reads, one per cycle, through the shared pointer incrementer;
// each result appears in the cycle after its read. An empty offer reads nothing.
// Reset clears state, head pointer and fill count; read pointer, level_o and RAM are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
// -----------------------------------------------------------------------------
module lossy_log_ring_packet_drain_core #(
  parameter int unsigned RING_DEPTH   = llrpd_pkg::RingDepthDef,
  parameter int unsigned PACKET_BYTES = llrpd_pkg::PacketBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [llrpd_pkg::KindW-1:0]   kind_i,
  input  logic [llrpd_pkg::DataW-1:0]   data_byte_i,
  input  logic [llrpd_pkg::AccW-1:0]    accepted_i,
  output logic                          result_valid_o,
  output logic [llrpd_pkg::DataW-1:0]   out_byte_o,
  output logic                          last_o,
  output logic [llrpd_pkg::LevelW-1:0]  level_o
);
  import llrpd_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned OW = PW + 1;
  localparam int unsigned RW = (CW > AccW) ? CW : AccW;
  localparam int unsigned KW = $clog2(PACKET_BYTES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_q, state_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [KW-1:0] remain_q, remain_d;
  logic [LevelW-1:0] level_q, level_d;
  logic          vld_q, last_q;

  logic          accept;
  logic [PW-1:0] step_in, step_out;
  logic [OW-1:0] wp_ext, fill_ext;
  logic [PW-1:0] oldest;
  logic [RW-1:0] fill_r, acc_r;
  logic          ram_we, ram_re;
  logic [DataW-1:0] ram_rdata;

  assign accept = start_i && (state_q == ST_IDLE);

  // shared pointer incrementer: head pointer when idle, read pointer in a run
  assign step_in  = (state_q == ST_RUN) ? rd_ptr_q : wr_ptr_q;
  assign step_out = (step_in == PW'(RING_DEPTH - 1)) ? '0 : step_in + PW'(1);

  // tail position: head minus level, modulo the ring depth
  assign wp_ext   = OW'(wr_ptr_q);
  assign fill_ext = OW'(fill_q);
  always_comb begin
    if (wp_ext >= fill_ext) begin
      oldest = PW'(wp_ext - fill_ext);
    end else begin
      oldest = PW'(wp_ext + OW'(RING_DEPTH) - fill_ext);
    end
  end

  assign fill_r = RW'(fill_q);
  assign acc_r  = RW'(accepted_i);

  // sequencer and command decode
  always_comb begin
    state_d  = state_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    rd_ptr_d = rd_ptr_q;
    remain_d = remain_q;
    level_d  = level_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_PUSH: begin
              ram_we   = 1'b1;
              wr_ptr_d = step_out;
              if (fill_q != CW'(RING_DEPTH)) begin
                fill_d = fill_q + CW'(1);
              end
            end
            KIND_OFFER: begin
              if (fill_q != '0) begin
                state_d  = ST_RUN;
                rd_ptr_d = oldest;
                level_d  = LevelW'(fill_q);
                if (fill_r > RW'(PACKET_BYTES)) begin
                  remain_d = KW'(PACKET_BYTES);
                end else begin
                  remain_d = KW'(fill_q);
                end
              end
            end
            KIND_RELEASE: begin
              if (acc_r >= fill_r) begin
                fill_d = '0;
              end else begin
                fill_d = CW'(fill_r - acc_r);
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        ram_re   = 1'b1;
        rd_ptr_d = step_out;
        remain_d = remain_q - KW'(1);
        if (remain_q == KW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      vld_q    <= (state_q == ST_RUN);
    end
  end

  // run context and result marker
  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    remain_q <= remain_d;
    level_q  <= level_d;
    last_q   <= (remain_q == KW'(1));
  end

  llrpd_ring_ram #(
    .Depth (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign busy_o         = (state_q == ST_RUN);
  assign result_valid_o = vld_q;
  assign out_byte_o     = ram_rdata;
  assign last_o         = last_q;
  assign level_o        = level_q;

  // checks
  a_run_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> result_valid_o)
    else $error("read cycle without a result transfer");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("final byte shown while still reading");

  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("run ended without a final byte");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(RING_DEPTH))
    else $error("level above ring depth");

endmodule

// ===== tb/tb_lossy_log_ring_packet_drain_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_lossy_log_ring_packet_drain_core: self-checking bench for the log ring
// Drives push, offer, release and unused commands through the start/busy
// handshake and checks every result strobe, field by field, against a
// behavioral ring kept in the bench. A short directed table covers the
// empty ring, single bytes, short runs and over-release. Random traffic
// follows, with push-heavy stretches that build the level toward a full packet.
// -----------------------------------------------------------------------------
module tb_lossy_log_ring_packet_drain_core;
  import llrpd_pkg::*;

  localparam int unsigned RingDepth   = RingDepthDef;
  localparam int unsigned PktBytes    = PacketBytesDef;
  localparam int unsigned PosW        = $clog2(RingDepth);
  localparam int unsigned StallLimit  = 1000;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  // one byte of an offered packet as the result port shows it
  typedef struct packed {
    logic [DataW-1:0]  data;
    logic              last;
    logic [LevelW-1:0] level;
  } pkt_byte_t;

  // directed command; typed_n < 0: predicted, else 0 or 1 typed result bytes
  typedef struct {
    logic [KindW-1:0]  kind;
    logic [DataW-1:0]  data;
    logic [AccW-1:0]   acc;
    int                typed_n;
    logic [DataW-1:0]  t_data;
    logic [LevelW-1:0] t_level;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [KindW-1:0]  kind_i;
  logic [DataW-1:0]  data_byte_i;
  logic [AccW-1:0]   accepted_i;
  logic              result_valid_o;
  logic [DataW-1:0]  out_byte_o;
  logic              last_o;
  logic [LevelW-1:0] level_o;

  // bench copy of the ring
  logic [DataW-1:0]  ring_mem [RingDepth];
  logic [PosW-1:0]   head_pos;
  logic [LevelW-1:0] fill_lvl;

  pkt_byte_t         offered_q[$];
  dir_row_t          dir_tab[25];

  bit                idle_on;
  int unsigned       err_cnt;
  int unsigned       n_items, n_push, n_offer, n_release, n_ignored;
  int unsigned       n_overwrite, n_checked, peak_lvl;
  int unsigned       stall_cnt;

  lossy_log_ring_packet_drain_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .accepted_i     (accepted_i),
    .result_valid_o (result_valid_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .level_o        (level_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // append at the head; a full ring keeps its level and loses the oldest byte
  function automatic void ring_push(logic [DataW-1:0] b);
    ring_mem[head_pos] = b;
    head_pos = (head_pos == PosW'(RingDepth - 1)) ? '0 : head_pos + 1'b1;
    if (fill_lvl < LevelW'(RingDepth)) begin
      fill_lvl = fill_lvl + 1'b1;
    end else begin
      n_overwrite++;
    end
    if (fill_lvl > peak_lvl) peak_lvl = fill_lvl;
  endfunction

  // queue the bytes an offer streams out, oldest first, nothing removed
  function automatic void ring_predict_offer();
    int unsigned n;
    int unsigned oldest;
    pkt_byte_t   pb;
    n = (fill_lvl > PktBytes) ? PktBytes : fill_lvl;
    oldest = (int'(head_pos) + RingDepth - fill_lvl) % RingDepth;
    for (int unsigned i = 0; i < n; i++) begin
      pb.data  = ring_mem[(oldest + i) % RingDepth];
      pb.last  = (i + 1 == n);
      pb.level = fill_lvl;
      offered_q.push_back(pb);
    end
  endfunction

  // drop bytes from the tail, never below empty
  function automatic void ring_release(logic [AccW-1:0] taken);
    if (LevelW'(taken) > fill_lvl) fill_lvl = '0;
    else fill_lvl = fill_lvl - LevelW'(taken);
  endfunction

  // one command transfer, optionally after a random gap; updates the bench ring
  task automatic send_cmd(input logic [KindW-1:0] k, input logic [DataW-1:0] d,
                          input logic [AccW-1:0] a, input int typed_n,
                          input logic [DataW-1:0] t_data,
                          input logic [LevelW-1:0] t_level);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    kind_i      <= k;
    data_byte_i <= d;
    accepted_i  <= a;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // transfer taken at this edge
    case (k)
      KIND_PUSH: begin
        n_push++;
        ring_push(d);
      end
      KIND_OFFER: begin
        n_offer++;
        if (typed_n < 0) ring_predict_offer();
        else if (typed_n > 0) offered_q.push_back('{t_data, 1'b1, t_level});
      end
      KIND_RELEASE: begin
        n_release++;
        ring_release(a);
      end
      default: n_ignored++;
    endcase
    if (k != KindUnused) n_items++;
  endtask

  // random command; mostly small releases so the ring keeps some content
  task automatic send_random(input int unsigned push_pct, input int unsigned offer_pct);
    int unsigned      roll;
    int unsigned      r;
    logic [KindW-1:0] k;
    logic [AccW-1:0]  a;
    roll = $urandom_range(0, 99);
    if (roll < 3) k = KindUnused;
    else if (roll < 3 + push_pct) k = KIND_PUSH;
    else if (roll < 3 + push_pct + offer_pct) k = KIND_OFFER;
    else k = KIND_RELEASE;
    r = $urandom_range(0, 9);
    if (r < 6) a = AccW'($urandom_range(0, 4));
    else if (r < 9) a = AccW'($urandom_range(0, 16));
    else a = AccW'($urandom_range(0, 127));
    send_cmd(k, DataW'($urandom), a, -1, '0, '0);
  endtask

  // hold off the sender until every expected byte is out
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (offered_q.size() != 0);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_chk
    pkt_byte_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      n_checked++;
      if (offered_q.size() == 0) begin
        err_cnt++;
        $error("unexpected result: out_byte %0h last %0b level %0d",
               out_byte_o, last_o, level_o);
      end else begin
        want = offered_q.pop_front();
        if (out_byte_o !== want.data) begin
          err_cnt++;
          $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
        end
        if (last_o !== want.last) begin
          err_cnt++;
          $error("last: expected %0b, got %0b", want.last, last_o);
        end
        if (level_o !== want.level) begin
          err_cnt++;
          $error("level: expected %0d, got %0d", want.level, level_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("no transfer for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // stimulus
  initial begin : stim
    int unsigned seg_push;
    int unsigned target;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    kind_i      <= KIND_PUSH;
    data_byte_i <= '0;
    accepted_i  <= '0;
    head_pos    = '0;
    fill_lvl    = '0;
    idle_on     = 1'b1;
    err_cnt     = 0;
    n_items     = 0;
    n_push      = 0;
    n_offer     = 0;
    n_release   = 0;
    n_ignored   = 0;
    n_overwrite = 0;
    n_checked   = 0;
    peak_lvl    = 0;
    stall_cnt   = 0;

    // empty ring, single bytes, zero and oversize releases, unused kind, short run
    dir_tab[0]  = '{KIND_OFFER,   8'h00, 7'd0,   0, 8'h00, 13'd0};
    dir_tab[1]  = '{KIND_RELEASE, 8'h00, 7'd127, -1, 8'h00, 13'd0};
    dir_tab[2]  = '{KIND_OFFER,   8'h00, 7'd0,   0, 8'h00, 13'd0};
    dir_tab[3]  = '{KIND_PUSH,    8'hFF, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[4]  = '{KIND_OFFER,   8'h00, 7'd0,   1, 8'hFF, 13'd1};
    dir_tab[5]  = '{KIND_RELEASE, 8'h00, 7'd1,   -1, 8'h00, 13'd0};
    dir_tab[6]  = '{KIND_OFFER,   8'h00, 7'd0,   0, 8'h00, 13'd0};
    dir_tab[7]  = '{KIND_PUSH,    8'h00, 7'd127, -1, 8'h00, 13'd0};
    dir_tab[8]  = '{KIND_RELEASE, 8'hFF, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[9]  = '{KIND_OFFER,   8'h00, 7'd0,   1, 8'h00, 13'd1};
    dir_tab[10] = '{KindUnused,   8'hAA, 7'd127, -1, 8'h00, 13'd0};
    dir_tab[11] = '{KIND_OFFER,   8'hFF, 7'd127, 1, 8'h00, 13'd1};
    dir_tab[12] = '{KIND_PUSH,    8'h55, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[13] = '{KIND_PUSH,    8'hAA, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[14] = '{KIND_PUSH,    8'h01, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[15] = '{KIND_PUSH,    8'h80, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[16] = '{KIND_OFFER,   8'h00, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[17] = '{KIND_RELEASE, 8'h00, 7'd3,   -1, 8'h00, 13'd0};
    dir_tab[18] = '{KIND_OFFER,   8'h00, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[19] = '{KIND_RELEASE, 8'h00, 7'd64,  -1, 8'h00, 13'd0};
    dir_tab[20] = '{KIND_OFFER,   8'h00, 7'd0,   0, 8'h00, 13'd0};
    dir_tab[21] = '{KIND_PUSH,    8'h7F, 7'd0,   -1, 8'h00, 13'd0};
    dir_tab[22] = '{KIND_OFFER,   8'h00, 7'd0,   1, 8'h7F, 13'd1};
    dir_tab[23] = '{KIND_RELEASE, 8'h00, 7'd65,  -1, 8'h00, 13'd0};
    dir_tab[24] = '{KIND_OFFER,   8'h00, 7'd0,   0, 8'h00, 13'd0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_cmd(dir_tab[i].kind, dir_tab[i].data, dir_tab[i].acc,
               dir_tab[i].typed_n, dir_tab[i].t_data, dir_tab[i].t_level);
    end
    wait_drained();

    // mixed traffic, push share changes every 30 commands
    target = n_items + 160;
    seg_push = 60;
    while (n_items < target) begin
      if (n_items % 30 == 0) seg_push = $urandom_range(40, 85);
      send_random(seg_push, (97 - seg_push) / 2);
    end
    wait_drained();

    // push-heavy stretch so offers run at the full packet length
    target = n_items + 40;
    while (n_items < target) send_random(60, 32);

    // closing stretch without gaps
    idle_on = 1'b0;
    target = n_items + 50;
    while (n_items < target) send_random(45, 30);

    wait_drained();
    repeat (PktBytes + 16) @(posedge clk_i);

    $display("Covered %0d pushes (%0d overwrote the oldest byte), %0d offers, %0d releases,",
             n_push, n_overwrite, n_offer, n_release);
    $display("  %0d ignored commands, %0d result bytes checked, peak level %0d",
             n_ignored, n_checked, peak_lvl);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
